### src/lsws_pkg.sv
// ----------------------------------------------------------------------------
// lsws_pkg: shared types and constants
// Widths, CSR map and the command/status types used between the sequencer
// and the slot table probe unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsws_pkg;

   // Default values of the top-level parameters.
   localparam int MAX_ITEMS_DEF   = 1024;
   localparam int TABLE_SLOTS_DEF = 2048;
   localparam int VALUE_BITS_DEF  = 16;

   // Fixed datapath widths.
   localparam int SUM_BITS   = 26;
   localparam int LEN_BITS   = 11;
   localparam int EXT_BITS   = 32;
   localparam int HASH_SHIFT = 11;
   localparam int EPOCH_BITS = 8;

   // Configuration port.
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TARGET_ADDR = 2'd0;

   typedef enum logic {
      OP_LOOKUP,
      OP_INSERT
   } probe_op_type;

   typedef struct packed {
      logic         start;
      probe_op_type op;
      logic         new_array;
   } probe_cmd_type;

   typedef struct packed {
      logic ready;
      logic done;
      logic found;
   } probe_stat_type;

endpackage

`default_nettype wire

### src/lsws_req_if.sv
// ----------------------------------------------------------------------------
// lsws_req_if: element input channel
// Valid/ready channel carrying one signed array element and its last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsws_req_if #(
   parameter int VALUE_BITS = lsws_pkg::VALUE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

### src/lsws_rsp_if.sv
// ----------------------------------------------------------------------------
// lsws_rsp_if: result output channel
// Valid/ready channel carrying the running longest length and its flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsws_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lsws_pkg::LEN_BITS-1:0] longest_len;
   logic                          done_res;
   logic                          overrun;

   modport source (output valid, output longest_len, output done_res, output overrun,
                   input ready);
   modport sink   (input valid, input longest_len, input done_res, input overrun,
                   output ready);
endinterface

`default_nettype wire

### src/longest_subarray_with_sum_core.sv
// ----------------------------------------------------------------------------
// longest_subarray_with_sum_core: longest subarray with a given sum
// Streams signed elements, keeps a running prefix sum and a first-occurrence
// table of prefix sums, and reports the longest run that sums to the target.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                          Transfer when
//   req_ch   in         value, last                      valid && ready
//   rsp_ch   out        longest_len, done_res, overrun   valid && ready
//   csr_*    in/out     target_sum at byte address 0     psel && penable && pwrite
//
// The lookup and insert probe chains of an element run one after the other,
// since the slot table RAM has a single read port; with no lookup needed only
// the insert runs, and an overrun element goes straight to the reply.
// Reset starts a clearing pass over every slot of the table; the same
// pass runs after every 255th array, when the epoch mark wraps. No element
// is taken during it. A stalled result waits in the output register while
// the next element is already being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module longest_subarray_with_sum_core #(
   parameter int MAX_ITEMS   = lsws_pkg::MAX_ITEMS_DEF,
   parameter int TABLE_SLOTS = lsws_pkg::TABLE_SLOTS_DEF,
   parameter int VALUE_BITS  = lsws_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   lsws_req_if.sink                                  req_ch,
   lsws_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [lsws_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [lsws_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [lsws_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready
);

   localparam int IDX_BITS = $clog2(MAX_ITEMS);
   localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);
   localparam int SB       = lsws_pkg::SUM_BITS;
   localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_ITEMS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_LOOKUP,
      S_INSERT,
      S_REPLY
   } state_type;

   state_type                     state_ff;
   logic [SB-1:0]                 sum_ff;
   logic [CNT_BITS-1:0]           count_ff;
   logic [CNT_BITS-1:0]           best_ff;
   logic                          over_ff;
   logic                          last_ff;
   logic [IDX_BITS-1:0]           idx_ff;
   logic                          rsp_valid_ff;
   logic [lsws_pkg::LEN_BITS-1:0] rsp_len_ff;
   logic                          rsp_done_ff;
   logic                          rsp_over_ff;

   logic [SB-1:0]                 target_sum;
   logic [SB-1:0]                 val_ext;
   logic [SB-1:0]                 sum_in;
   logic [SB:0]                   want;
   logic                          want_ok;
   logic                          sum_eq;
   logic                          do_lookup;
   logic [IDX_BITS-1:0]           hit_index;
   logic [IDX_BITS-1:0]           span;
   logic [CNT_BITS-1:0]           span_ext;
   logic                          req_ready;
   logic                          rsp_load;
   logic [SB-1:0]                 probe_key;
   lsws_pkg::probe_cmd_type       pcmd;
   lsws_pkg::probe_stat_type      pstat;

   lsws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .target_sum  (target_sum)
   );

   lsws_probe #(
      .MAX_ITEMS   (MAX_ITEMS),
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_probe (
      .clock     (clock),
      .reset     (reset),
      .cmd       (pcmd),
      .key       (probe_key),
      .wr_index  (idx_ff),
      .stat      (pstat),
      .hit_index (hit_index)
   );

   // Element sign-extended, then wrapped to the prefix-sum width.
   assign val_ext = SB'(lsws_pkg::EXT_BITS'($signed(req_ch.value[VALUE_BITS-1:0])));
   assign sum_in  = sum_ff + val_ext;

   // The difference is exact in one extra bit; outside the key range it
   // cannot match any stored prefix sum.
   assign want      = {sum_ff[SB-1], sum_ff} - {target_sum[SB-1], target_sum};
   assign want_ok   = (want[SB] == want[SB-1]);
   assign sum_eq    = (sum_ff == target_sum);
   assign do_lookup = !sum_eq && want_ok;

   assign span     = idx_ff - hit_index;
   assign span_ext = CNT_BITS'(span);

   assign req_ready = (state_ff == S_IDLE) && pstat.ready;
   assign rsp_load  = (state_ff == S_REPLY) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      pcmd.start     = 1'b0;
      pcmd.op        = lsws_pkg::OP_INSERT;
      pcmd.new_array = 1'b0;
      case (state_ff)
         S_MATCH: begin
            pcmd.start = 1'b1;
            pcmd.op    = do_lookup ? lsws_pkg::OP_LOOKUP : lsws_pkg::OP_INSERT;
         end
         S_LOOKUP: begin
            pcmd.start = pstat.done;
         end
         S_REPLY: begin
            pcmd.new_array = rsp_load && last_ff;
         end
         default: begin
            pcmd.start = 1'b0;
         end
      endcase
   end

   assign probe_key = (pcmd.op == lsws_pkg::OP_LOOKUP) ? want[SB-1:0] : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         best_ff      <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid && req_ready) begin
                  last_ff <= req_ch.last;
                  if (count_ff == MAX_CNT) begin
                     over_ff  <= 1'b1;
                     state_ff <= S_REPLY;
                  end else begin
                     sum_ff   <= sum_in;
                     idx_ff   <= count_ff[IDX_BITS-1:0];
                     count_ff <= count_ff + 1'b1;
                     state_ff <= S_MATCH;
                  end
               end
            end
            S_MATCH: begin
               // count_ff already holds index plus one.
               if (sum_eq) begin
                  best_ff <= count_ff;
               end
               state_ff <= do_lookup ? S_LOOKUP : S_INSERT;
            end
            S_LOOKUP: begin
               if (pstat.done) begin
                  if (pstat.found && span_ext > best_ff) begin
                     best_ff <= span_ext;
                  end
                  state_ff <= S_INSERT;
               end
            end
            S_INSERT: begin
               if (pstat.done) begin
                  state_ff <= S_REPLY;
               end
            end
            S_REPLY: begin
               if (rsp_load) begin
                  rsp_len_ff   <= lsws_pkg::LEN_BITS'(best_ff);
                  rsp_done_ff  <= last_ff;
                  rsp_over_ff  <= over_ff;
                  if (last_ff) begin
                     sum_ff   <= '0;
                     count_ff <= '0;
                     best_ff  <= '0;
                     over_ff  <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.longest_len = rsp_len_ff;
   assign rsp_ch.done_res    = rsp_done_ff;
   assign rsp_ch.overrun     = rsp_over_ff;

`ifndef SYNTHESIS
   a_probe_idle_on_cmd: assert property (@(posedge clock) disable iff (reset)
      (pcmd.start || pcmd.new_array) |-> pstat.ready)
      else $error("slot table command issued while the probe unit is busy");

   a_best_bounded: assert property (@(posedge clock) disable iff (reset)
      (best_ff <= count_ff) && (count_ff <= MAX_CNT))
      else $error("best length or element count out of bounds");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last_ff) |=> (count_ff == '0 && sum_ff == '0 && best_ff == '0))
      else $error("array state not cleared after its final element");

   a_done_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      pstat.done |-> (state_ff == S_LOOKUP || state_ff == S_INSERT))
      else $error("probe completion outside a lookup or insert");
`endif

endmodule

`default_nettype wire

### src/lsws_csr.sv
// ----------------------------------------------------------------------------
// lsws_csr: configuration registers
// APB-style register file holding the signed target sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsws_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [lsws_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [lsws_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [lsws_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready,
   output logic      [lsws_pkg::SUM_BITS-1:0]        target_sum
);

   logic [lsws_pkg::SUM_BITS-1:0] target_ff;
   logic                          wr_hit;

   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr == lsws_pkg::CSR_TARGET_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (wr_hit) begin
         target_ff <= csr_pwdata[lsws_pkg::SUM_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == lsws_pkg::CSR_TARGET_ADDR) begin
         csr_prdata = lsws_pkg::CSR_DATA_BITS'($signed(target_ff));
      end
   end

   assign csr_pready = 1'b1;
   assign target_sum = target_ff;

endmodule

`default_nettype wire

### src/lsws_probe.sv
// ----------------------------------------------------------------------------
// lsws_probe: prefix-sum slot table
// Linear-probing hash table in one synchronous RAM. Each entry holds an
// epoch mark, the prefix-sum key and the index where it first occurred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsws_probe #(
   parameter int MAX_ITEMS   = lsws_pkg::MAX_ITEMS_DEF,
   parameter int TABLE_SLOTS = lsws_pkg::TABLE_SLOTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lsws_pkg::probe_cmd_type           cmd,
   input  wire logic [lsws_pkg::SUM_BITS-1:0]     key,
   input  wire logic [$clog2(MAX_ITEMS)-1:0]      wr_index,
   output lsws_pkg::probe_stat_type               stat,
   output logic      [$clog2(MAX_ITEMS)-1:0]      hit_index
);

   localparam int IDX_BITS   = $clog2(MAX_ITEMS);
   localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
   localparam int ENTRY_BITS = lsws_pkg::EPOCH_BITS + lsws_pkg::SUM_BITS + IDX_BITS;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);
   localparam logic [lsws_pkg::EPOCH_BITS-1:0] FIRST_EPOCH = lsws_pkg::EPOCH_BITS'(1);

   typedef enum logic [1:0] {
      P_SWEEP,
      P_IDLE,
      P_PROBE
   } pstate_type;

   pstate_type                        state_ff;
   lsws_pkg::probe_op_type            op_ff;
   logic [lsws_pkg::SUM_BITS-1:0]     key_ff;
   logic [IDX_BITS-1:0]               idx_ff;
   logic [SLOT_BITS-1:0]              pos_ff;
   logic [SLOT_BITS-1:0]              tries_ff;
   logic [SLOT_BITS-1:0]              sweep_ff;
   logic [lsws_pkg::EPOCH_BITS-1:0]   epoch_ff;
   logic                              done_ff;
   logic                              found_ff;
   logic [IDX_BITS-1:0]               hit_ff;

   logic [ENTRY_BITS-1:0]             mem [TABLE_SLOTS];
   logic [ENTRY_BITS-1:0]             rd_data_ff;
   logic [SLOT_BITS-1:0]              rd_addr;
   logic                              wr_en;
   logic [SLOT_BITS-1:0]              wr_addr;
   logic [ENTRY_BITS-1:0]             wr_data;

   logic [lsws_pkg::EPOCH_BITS-1:0]   ent_epoch;
   logic [lsws_pkg::SUM_BITS-1:0]     ent_key;
   logic [IDX_BITS-1:0]               ent_idx;
   logic                              ent_valid;
   logic                              ent_hit;
   logic                              probe_end;
   logic [SLOT_BITS-1:0]              home;
   logic [lsws_pkg::SUM_BITS-1:0]     hash_mix;

   // Home slot: fold the upper key bits onto the lower ones.
   assign hash_mix = key ^ (key >> lsws_pkg::HASH_SHIFT);
   assign home     = hash_mix[SLOT_BITS-1:0];

   assign ent_epoch = rd_data_ff[ENTRY_BITS-1 -: lsws_pkg::EPOCH_BITS];
   assign ent_key   = rd_data_ff[IDX_BITS +: lsws_pkg::SUM_BITS];
   assign ent_idx   = rd_data_ff[IDX_BITS-1:0];

   // An entry written during an earlier array carries a stale epoch and reads
   // as empty. Epoch zero is only ever written by the clearing pass.
   assign ent_valid = (ent_epoch == epoch_ff);
   assign ent_hit   = ent_valid && (ent_key == key_ff);
   assign probe_end = !ent_valid || ent_hit || (tries_ff == LAST_SLOT);

   always_comb begin
      rd_addr = pos_ff;
      if (state_ff == P_IDLE && cmd.start) begin
         rd_addr = home;
      end else if (state_ff == P_PROBE && !probe_end) begin
         rd_addr = pos_ff + 1'b1;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = {epoch_ff, key_ff, idx_ff};
      if (state_ff == P_SWEEP) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = '0;
      end else if (state_ff == P_PROBE && op_ff == lsws_pkg::OP_INSERT && !ent_valid) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_SWEEP;
         sweep_ff <= '0;
         epoch_ff <= FIRST_EPOCH;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         case (state_ff)
            P_SWEEP: begin
               done_ff  <= 1'b0;
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == LAST_SLOT) begin
                  state_ff <= P_IDLE;
               end
            end
            P_IDLE: begin
               done_ff <= 1'b0;
               if (cmd.new_array) begin
                  if (epoch_ff == '1) begin
                     epoch_ff <= FIRST_EPOCH;
                     sweep_ff <= '0;
                     state_ff <= P_SWEEP;
                  end else begin
                     epoch_ff <= epoch_ff + 1'b1;
                  end
               end else if (cmd.start) begin
                  op_ff    <= cmd.op;
                  key_ff   <= key;
                  idx_ff   <= wr_index;
                  pos_ff   <= home;
                  tries_ff <= '0;
                  state_ff <= P_PROBE;
               end
            end
            P_PROBE: begin
               done_ff <= probe_end;
               if (probe_end) begin
                  found_ff <= ent_hit;
                  hit_ff   <= ent_idx;
                  state_ff <= P_IDLE;
               end else begin
                  pos_ff   <= pos_ff + 1'b1;
                  tries_ff <= tries_ff + 1'b1;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= P_IDLE;
            end
         endcase
      end
   end

   assign stat.ready = (state_ff == P_IDLE);
   assign stat.done  = done_ff;
   assign stat.found = found_ff;
   assign hit_index  = hit_ff;

endmodule

`default_nettype wire
